// ----- design/erlp_pkg.sv -----
// Shared types and constants for the escaped record line parser.
// Holds the queue record layout, verdict codes and register indexes.
// No dependencies.
package erlp_pkg;

   // widths fixed by the field layout
   localparam int CFG_W       = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int STAMP_W     = 63;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MSGID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AUTHOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SOURCE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TEXT   = 2'd3;

   // verdict codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_LONG     = 3'd1;
   localparam logic [2:0] ST_DANGLING = 3'd2;
   localparam logic [2:0] ST_FEW      = 3'd3;
   localparam logic [2:0] ST_BADSTAMP = 3'd4;
   localparam logic [2:0] ST_EMPTYID  = 3'd5;

   // result kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // field numbers
   localparam logic [2:0] FIELD_STAMP = 3'd0;
   localparam logic [2:0] FIELD_MSGID = 3'd1;
   localparam logic [2:0] FIELD_TEXT  = 3'd4;

   // everything one accepted byte leaves for the result side
   typedef struct packed {
      logic [1:0]         n_data;
      logic [2:0]         field;
      logic [7:0]         data0;
      logic [7:0]         data1;
      logic               verdict;
      logic [2:0]         status;
      logic [STAMP_W-1:0] stamp;
   } rec_type;

endpackage

// ----- design/escaped_record_line_parser_core.sv -----
// Record line parser core: joins the parse front end, the record queue and
// the result back end. Depends on erlp_pkg, erlp_front, erlp_fifo, erlp_back.
//
// Feed a record line one raw byte per transfer, with req_line_last on its
// final byte. The front end takes a byte in every cycle while the record
// queue (four entries) has room; each byte leaves zero to three results
// (decoded data bytes of fields one to four, plus the verdict after the last
// byte), and the back end sends one result per cycle through a registered
// output while rsp_ready is high. Sustained throughput is therefore one byte
// per cycle while each byte yields at most one result, and one result per
// cycle otherwise; the first result of a byte passes through the record
// queue and the output register before it is offered on rsp_valid. Lengths
// are capped at FIELD_LIMIT_MAX, the timestamp field allows STAMP_BUF-1 bytes.
// Write the csr_ registers only while no line is in flight.
module escaped_record_line_parser_core import erlp_pkg::*; #(
   parameter int FIELD_LIMIT_MAX = 4095,
   parameter int STAMP_BUF       = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_line_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [2:0]           rsp_field_number,
   output logic [7:0]           rsp_out_byte,
   output logic [2:0]           rsp_status,
   output logic [STAMP_W-1:0]   rsp_stamp,
   output logic                 rsp_run_last,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic    push, full, pop, empty;
   rec_type push_rec, head;

   erlp_front #(
      .FIELD_LIMIT_MAX (FIELD_LIMIT_MAX),
      .STAMP_BUF       (STAMP_BUF)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_line_last (req_line_last),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .queue_full    (full),
      .push          (push),
      .push_rec      (push_rec)
   );

   erlp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (full),
      .pop      (pop),
      .head     (head),
      .empty    (empty)
   );

   erlp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_field_number (rsp_field_number),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_status       (rsp_status),
      .rsp_stamp        (rsp_stamp),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

// ----- design/erlp_front.sv -----
// Front end of the record line parser: takes one raw byte per transfer,
// undoes escapes, tracks fields and the timestamp, and builds queue records.
// Depends on erlp_pkg.
module erlp_front import erlp_pkg::*; #(
   parameter int FIELD_LIMIT_MAX = 4095,
   parameter int STAMP_BUF       = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_line_last,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 queue_full,
   output logic                 push,
   output rec_type              push_rec
);

   localparam int LEN_W = $clog2(FIELD_LIMIT_MAX + 1);
   localparam int CMP_W = ((LEN_W > CFG_W) ? LEN_W : CFG_W) + 1;
   localparam int PROD_W = STAMP_W + 4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_LO_N  = 8'h6E;
   localparam logic [7:0] CH_LO_R  = 8'h72;
   localparam logic [7:0] CH_LO_T  = 8'h74;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS,
      PH_BAD
   } stamp_phase_type;

   // configuration registers
   logic [CFG_W-1:0] max_msgid_ff, max_author_ff, max_source_ff, max_text_ff;

   // line state
   logic [2:0]         field_ff, field_in;
   logic               esc_ff, esc_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [2:0]         err_ff, err_in;
   logic               stop_ff, stop_in;
   logic [STAMP_W-1:0] val_ff, val_in;
   stamp_phase_type    phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic               msg_ff, msg_in;

   logic               accept;
   logic               is_stop;
   logic [CMP_W-1:0]   lim_raw, lim, len_ext;
   logic               fit1, fit2;
   logic               want1, want2;
   logic [7:0]         ch0;
   logic [1:0]         n_data;
   logic               stamp_bad;
   logic               ch_space, ch_digit;
   logic [PROD_W-1:0]  prod;
   logic [2:0]         status;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_stop   = (req_in_byte == CH_NUL) || (req_in_byte == CH_LF) ||
                      (req_in_byte == CH_CR);

   // pick and cap the length limit of the current field
   always_comb begin
      unique case (field_ff)
         3'd0:    lim_raw = CMP_W'(STAMP_BUF - 1);
         3'd1:    lim_raw = CMP_W'(max_msgid_ff);
         3'd2:    lim_raw = CMP_W'(max_author_ff);
         3'd3:    lim_raw = CMP_W'(max_source_ff);
         default: lim_raw = CMP_W'(max_text_ff);
      endcase
      lim     = (lim_raw > CMP_W'(FIELD_LIMIT_MAX)) ? CMP_W'(FIELD_LIMIT_MAX) : lim_raw;
      len_ext = CMP_W'(len_ff);
      fit1    = len_ext < lim;
      fit2    = (len_ext + CMP_W'(1)) < lim;
   end

   // timestamp field checks and times-ten accumulate
   assign stamp_bad = (phase_ff != PH_DIGITS) || (neg_ff && (val_ff != '0));
   assign ch_space  = (ch0 == CH_SPACE) || ((ch0 >= CH_TAB) && (ch0 <= CH_CR));
   assign ch_digit  = (ch0 >= CH_ZERO) && (ch0 <= CH_NINE);
   assign prod      = (PROD_W'(val_ff) << 3) + (PROD_W'(val_ff) << 1) +
                      PROD_W'(ch0[3:0]);

   // parse one byte
   always_comb begin
      field_in = field_ff;
      esc_in   = esc_ff;
      len_in   = len_ff;
      err_in   = err_ff;
      stop_in  = stop_ff;
      val_in   = val_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      msg_in   = msg_ff;
      want1    = 1'b0;
      want2    = 1'b0;
      ch0      = req_in_byte;
      n_data   = 2'd0;
      status   = ST_OK;

      if (!stop_ff) begin
         if (is_stop) begin
            if (esc_ff) begin
               err_in = ST_DANGLING;
               esc_in = 1'b0;
            end
            stop_in = 1'b1;
         end else if (esc_ff) begin
            esc_in = 1'b0;
            want1  = 1'b1;
            case (req_in_byte)
               CH_LO_N:  ch0 = CH_LF;
               CH_LO_R:  ch0 = CH_CR;
               CH_LO_T:  ch0 = CH_TAB;
               CH_COLON: ch0 = CH_COLON;
               CH_BSL:   ch0 = CH_BSL;
               default: begin
                  ch0   = CH_BSL;
                  want2 = 1'b1;
               end
            endcase
         end else if (req_in_byte == CH_BSL) begin
            esc_in = 1'b1;
         end else if ((req_in_byte == CH_COLON) && (field_ff < FIELD_TEXT)) begin
            if ((field_ff == FIELD_STAMP) && stamp_bad) begin
               err_in  = ST_BADSTAMP;
               stop_in = 1'b1;
            end else begin
               field_in = field_ff + 3'd1;
               len_in   = '0;
            end
         end else begin
            want1 = 1'b1;
         end
      end

      // append one or two decoded bytes
      if (want1) begin
         if (!fit1) begin
            err_in  = ST_LONG;
            stop_in = 1'b1;
         end else begin
            len_in = LEN_W'(len_ff + 1'b1);
            if (want2 && !fit2) begin
               err_in  = ST_LONG;
               stop_in = 1'b1;
            end else if (want2) begin
               len_in = LEN_W'(len_ff + 2'd2);
            end
            if (field_ff == FIELD_STAMP) begin
               // a second byte after a backslash cannot recover a bad stamp
               priority if ((phase_ff == PH_LEAD) && ch_space) begin
                  phase_in = phase_ff;
               end else if ((phase_ff == PH_LEAD) &&
                            ((ch0 == CH_PLUS) || (ch0 == CH_MINUS))) begin
                  neg_in   = (ch0 == CH_MINUS);
                  phase_in = PH_SIGN;
               end else if ((phase_ff == PH_BAD) || !ch_digit) begin
                  phase_in = PH_BAD;
               end else if (prod[PROD_W-1:STAMP_W] != '0) begin
                  phase_in = PH_BAD;
               end else begin
                  val_in   = prod[STAMP_W-1:0];
                  phase_in = PH_DIGITS;
               end
            end else begin
               n_data = (want2 && fit2) ? 2'd2 : 2'd1;
               if (field_ff == FIELD_MSGID) begin
                  msg_in = 1'b1;
               end
            end
         end
      end

      // end-of-line verdict, first error wins
      priority if (err_in != ST_OK) begin
         status = err_in;
      end else if (esc_in) begin
         status = ST_DANGLING;
      end else if (field_in < FIELD_TEXT) begin
         status = ST_FEW;
      end else if (!msg_in) begin
         status = ST_EMPTYID;
      end else begin
         status = ST_OK;
      end
   end

   // build the queue record
   always_comb begin
      push_rec.n_data  = n_data;
      push_rec.field   = field_ff;
      push_rec.data0   = ch0;
      push_rec.data1   = req_in_byte;
      push_rec.verdict = req_line_last;
      push_rec.status  = status;
      push_rec.stamp   = (status == ST_OK) ? val_in : '0;
   end

   assign push = accept && ((n_data != 2'd0) || req_line_last);

   // hold registers and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_msgid_ff  <= CFG_W'(127);
         max_author_ff <= CFG_W'(127);
         max_source_ff <= CFG_W'(127);
         max_text_ff   <= CFG_W'(4095);
         field_ff      <= FIELD_STAMP;
         esc_ff        <= 1'b0;
         len_ff        <= '0;
         err_ff        <= ST_OK;
         stop_ff       <= 1'b0;
         val_ff        <= '0;
         phase_ff      <= PH_LEAD;
         neg_ff        <= 1'b0;
         msg_ff        <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MAX_MSGID:  max_msgid_ff  <= csr_wdata;
               CSR_MAX_AUTHOR: max_author_ff <= csr_wdata;
               CSR_MAX_SOURCE: max_source_ff <= csr_wdata;
               CSR_MAX_TEXT:   max_text_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            if (req_line_last) begin
               // clear the line after its verdict
               field_ff <= FIELD_STAMP;
               esc_ff   <= 1'b0;
               len_ff   <= '0;
               err_ff   <= ST_OK;
               stop_ff  <= 1'b0;
               val_ff   <= '0;
               phase_ff <= PH_LEAD;
               neg_ff   <= 1'b0;
               msg_ff   <= 1'b0;
            end else begin
               field_ff <= field_in;
               esc_ff   <= esc_in;
               len_ff   <= len_in;
               err_ff   <= err_in;
               stop_ff  <= stop_in;
               val_ff   <= val_in;
               phase_ff <= phase_in;
               neg_ff   <= neg_in;
               msg_ff   <= msg_in;
            end
         end
      end
   end

endmodule

// ----- design/erlp_fifo.sv -----
// Short record queue between the parse front end and the result back end.
// Depends on erlp_pkg.
module erlp_fifo import erlp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output rec_type head,
   output logic    empty
);

   rec_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   // track fill level
   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // store records
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ----- design/erlp_back.sv -----
// Back end of the record line parser: splits each queued record into its
// data and verdict results and drives the registered result channel.
// Depends on erlp_pkg.
module erlp_back import erlp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  rec_type            head,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [2:0]         rsp_field_number,
   output logic [7:0]         rsp_out_byte,
   output logic [2:0]         rsp_status,
   output logic [STAMP_W-1:0] rsp_stamp,
   output logic               rsp_run_last
);

   logic [1:0]         sub_ff, sub_in;
   logic               valid_ff, valid_in;
   logic               kind_ff, kind_in;
   logic [2:0]         field_ff, field_in;
   logic [7:0]         byte_ff, byte_in;
   logic [2:0]         status_ff, status_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic               last_ff, last_in;
   logic               load;
   logic [1:0]         total;
   logic               is_last;

   assign load    = !empty && (!valid_ff || rsp_ready);
   assign total   = head.n_data + {1'b0, head.verdict};
   assign is_last = ((sub_ff + 2'd1) == total);
   assign pop     = load && is_last;

   // select the next result of the head record
   always_comb begin
      sub_in    = sub_ff;
      valid_in  = valid_ff && !rsp_ready;
      kind_in   = kind_ff;
      field_in  = field_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      stamp_in  = stamp_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = is_last;
         sub_in   = is_last ? 2'd0 : sub_ff + 2'd1;
         if (sub_ff < head.n_data) begin
            kind_in   = KIND_DATA;
            field_in  = head.field;
            byte_in   = sub_ff[0] ? head.data1 : head.data0;
            status_in = ST_OK;
            stamp_in  = '0;
         end else begin
            kind_in   = KIND_VERDICT;
            field_in  = FIELD_STAMP;
            byte_in   = '0;
            status_in = head.status;
            stamp_in  = head.stamp;
         end
      end
   end

   // hold the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
      kind_ff   <= kind_in;
      field_ff  <= field_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
      stamp_ff  <= stamp_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_field_number = field_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_status       = status_ff;
   assign rsp_stamp        = stamp_ff;
   assign rsp_run_last     = last_ff;

endmodule
